### rtl/core/utf8_text_console_cursor_engine_unit_macros.svh
// Assertion macros for the cursor engine checker.
`ifndef UTF8_TEXT_CONSOLE_CURSOR_ENGINE_UNIT_MACROS_SVH
`define UTF8_TEXT_CONSOLE_CURSOR_ENGINE_UNIT_MACROS_SVH

// Property checked at every edge outside reset.
`define UCCE_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Property checked at every edge, reset included.
`define UCCE_ASSERT_RESET(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/ucce_pkg.sv
// Shared types, codes and the CP1251 map for the text console cursor engine.
`timescale 1ns / 1ps
`default_nettype none
package ucce_pkg;

   localparam int TAB_STOP    = 8;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // func codes of an input beat
   localparam logic [1:0] FUNC_PUT_BYTE   = 2'd0;
   localparam logic [1:0] FUNC_SET_CURSOR = 2'd1;
   localparam logic [1:0] FUNC_CLEAR      = 2'd2;

   // csr register indexes
   localparam int         CSR_INDEX_W        = 2;
   localparam logic [1:0] CSR_TEXT_COLUMNS   = 2'd0;
   localparam logic [1:0] CSR_TEXT_ROWS      = 2'd1;
   localparam logic [1:0] CSR_CONSOLE_ENABLE = 2'd2;

   localparam logic [7:0] RESET_TEXT_COLUMNS   = 8'd128;
   localparam logic [7:0] RESET_TEXT_ROWS      = 8'd48;
   localparam logic       RESET_CONSOLE_ENABLE = 1'b1;

   // control and glyph characters
   localparam logic [7:0] CHAR_BS       = 8'h08;
   localparam logic [7:0] CHAR_TAB      = 8'h09;
   localparam logic [7:0] CHAR_LF       = 8'h0A;
   localparam logic [7:0] CHAR_CR       = 8'h0D;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_QUESTION = 8'h3F;
   localparam logic [7:0] CHAR_ASCII_END = 8'h80;

   // commands from front to back
   localparam logic [2:0] OP_NONE      = 3'd0;
   localparam logic [2:0] OP_SET       = 3'd1;
   localparam logic [2:0] OP_CLEAR     = 3'd2;
   localparam logic [2:0] OP_NEWLINE   = 3'd3;
   localparam logic [2:0] OP_RETURN    = 3'd4;
   localparam logic [2:0] OP_BACKSPACE = 3'd5;
   localparam logic [2:0] OP_TAB       = 3'd6;
   localparam logic [2:0] OP_GLYPH     = 3'd7;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] data_byte;
      logic [7:0] new_col;
      logic [7:0] new_row;
   } req_type;

   typedef struct packed {
      logic       draw_valid;
      logic [7:0] glyph_code;
      logic [7:0] glyph_col;
      logic [7:0] glyph_row;
      logic       scroll_request;
      logic       clear_request;
      logic [7:0] cursor_col;
      logic [7:0] cursor_row;
   } rsp_type;

   typedef struct packed {
      logic [7:0] text_columns;
      logic [7:0] text_rows;
      logic       console_enable;
   } cfg_type;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] code;
      logic [7:0] col;
      logic [7:0] row;
      logic       clear_flag;
   } cmd_type;

   // Unicode code point to CP1251; unmapped points give '?'.
   function automatic logic [7:0] map_cp1251(input logic [20:0] cp);
      logic [7:0]  code;
      logic [20:0] offset;
      offset = cp - 21'h000410;
      if (cp < 21'h000080) begin
         code = cp[7:0];
      end else if (cp inside {[21'h000410:21'h00044F]}) begin
         code = 8'hC0 + offset[7:0];
      end else begin
         case (cp)
            21'h000402: code = 8'h80;
            21'h000403: code = 8'h81;
            21'h00201A: code = 8'h82;
            21'h000453: code = 8'h83;
            21'h00201E: code = 8'h84;
            21'h002026: code = 8'h85;
            21'h002020: code = 8'h86;
            21'h002021: code = 8'h87;
            21'h0020AC: code = 8'h88;
            21'h002030: code = 8'h89;
            21'h000409: code = 8'h8A;
            21'h002039: code = 8'h8B;
            21'h00040A: code = 8'h8C;
            21'h00040C: code = 8'h8D;
            21'h00040B: code = 8'h8E;
            21'h00040F: code = 8'h8F;
            21'h000452: code = 8'h90;
            21'h002018: code = 8'h91;
            21'h002019: code = 8'h92;
            21'h00201C: code = 8'h93;
            21'h00201D: code = 8'h94;
            21'h002022: code = 8'h95;
            21'h002013: code = 8'h96;
            21'h002014: code = 8'h97;
            21'h002122: code = 8'h99;
            21'h000459: code = 8'h9A;
            21'h00203A: code = 8'h9B;
            21'h00045A: code = 8'h9C;
            21'h00045C: code = 8'h9D;
            21'h00045B: code = 8'h9E;
            21'h00045F: code = 8'h9F;
            21'h0000A0: code = 8'hA0;
            21'h00040E: code = 8'hA1;
            21'h00045E: code = 8'hA2;
            21'h000408: code = 8'hA3;
            21'h0000A4: code = 8'hA4;
            21'h000490: code = 8'hA5;
            21'h0000A6: code = 8'hA6;
            21'h0000A7: code = 8'hA7;
            21'h000401: code = 8'hA8;
            21'h0000A9: code = 8'hA9;
            21'h000404: code = 8'hAA;
            21'h0000AB: code = 8'hAB;
            21'h0000AC: code = 8'hAC;
            21'h0000AD: code = 8'hAD;
            21'h0000AE: code = 8'hAE;
            21'h000407: code = 8'hAF;
            21'h0000B0: code = 8'hB0;
            21'h0000B1: code = 8'hB1;
            21'h000406: code = 8'hB2;
            21'h000456: code = 8'hB3;
            21'h000491: code = 8'hB4;
            21'h0000B5: code = 8'hB5;
            21'h0000B6: code = 8'hB6;
            21'h0000B7: code = 8'hB7;
            21'h000451: code = 8'hB8;
            21'h002116: code = 8'hB9;
            21'h000454: code = 8'hBA;
            21'h0000BB: code = 8'hBB;
            21'h000458: code = 8'hBC;
            21'h000405: code = 8'hBD;
            21'h000455: code = 8'hBE;
            21'h000457: code = 8'hBF;
            default:    code = CHAR_QUESTION;
         endcase
      end
      return code;
   endfunction

endpackage
`default_nettype wire

### rtl/core/ucce_front.sv
// Front end: accepts beats, runs the UTF-8 decoder and emits one command per beat.
`timescale 1ns / 1ps
`default_nettype none
module ucce_front
   import ucce_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   input  cfg_type cfg,
   output logic    cmd_push,
   output cmd_type cmd_data,
   input  logic    cmd_full
);

   logic [20:0] acc_ff, acc_in;
   logic [1:0]  pend_ff, pend_in;
   logic [20:0] acc_shift;
   logic [7:0]  b;
   logic        accept;

   assign req_full = cmd_full;
   assign accept   = req_push & ~cmd_full;
   assign cmd_push = accept;
   assign b        = req_data.data_byte;
   assign acc_shift = {acc_ff[14:0], b[5:0]};

   always_comb begin
      acc_in              = acc_ff;
      pend_in             = pend_ff;
      cmd_data            = '0;
      cmd_data.op         = OP_NONE;
      cmd_data.col        = req_data.new_col;
      cmd_data.row        = req_data.new_row;
      case (req_data.func)
         FUNC_SET_CURSOR: begin
            cmd_data.op = OP_SET;
         end
         FUNC_CLEAR: begin
            cmd_data.op         = OP_CLEAR;
            cmd_data.clear_flag = cfg.console_enable;
         end
         FUNC_PUT_BYTE: begin
            if (cfg.console_enable) begin
               if (b == CHAR_LF) begin
                  cmd_data.op = OP_NEWLINE;
                  acc_in      = '0;
                  pend_in     = '0;
               end else if (b == CHAR_CR) begin
                  cmd_data.op = OP_RETURN;
                  acc_in      = '0;
                  pend_in     = '0;
               end else if (b == CHAR_BS) begin
                  cmd_data.op = OP_BACKSPACE;
                  acc_in      = '0;
                  pend_in     = '0;
               end else if (b == CHAR_TAB) begin
                  cmd_data.op = OP_TAB;
                  acc_in      = '0;
                  pend_in     = '0;
               end else if (b < CHAR_SPACE) begin
                  // other controls: no effect, pending sequence kept
                  cmd_data.op = OP_NONE;
               end else if (b < CHAR_ASCII_END && pend_ff == 2'd0) begin
                  cmd_data.op   = OP_GLYPH;
                  cmd_data.code = b;
               end else if (pend_ff == 2'd0) begin
                  // lead bytes; stray continuation and 0xF8+ ignored
                  if (b inside {[8'hC0:8'hDF]}) begin
                     acc_in  = {16'd0, b[4:0]};
                     pend_in = 2'd1;
                  end else if (b inside {[8'hE0:8'hEF]}) begin
                     acc_in  = {17'd0, b[3:0]};
                     pend_in = 2'd2;
                  end else if (b inside {[8'hF0:8'hF7]}) begin
                     acc_in  = {18'd0, b[2:0]};
                     pend_in = 2'd3;
                  end
               end else if (b[7:6] != 2'b10) begin
                  acc_in  = '0;
                  pend_in = '0;
               end else begin
                  acc_in  = acc_shift;
                  pend_in = pend_ff - 2'd1;
                  if (pend_ff == 2'd1) begin
                     cmd_data.op   = OP_GLYPH;
                     cmd_data.code = map_cp1251(acc_shift);
                     acc_in        = '0;
                  end
               end
            end
         end
         default: begin
            cmd_data.op = OP_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         pend_ff <= '0;
      end else if (accept) begin
         acc_ff  <= acc_in;
         pend_ff <= pend_in;
      end
   end

endmodule
`default_nettype wire

### rtl/core/ucce_cmd_queue.sv
// Short command queue between front end and back end.
`timescale 1ns / 1ps
`default_nettype none
module ucce_cmd_queue
   import ucce_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type head
);

   cmd_type                 q_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;
   logic                    do_push, do_pop;

   assign full    = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign head    = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

### rtl/core/ucce_back.sv
// Back end: runs commands on the cursor and queues the results.
`timescale 1ns / 1ps
`default_nettype none
module ucce_back
   import ucce_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    cmd_empty,
   input  cmd_type cmd_head,
   output logic    cmd_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   logic [7:0]             col_ff, col_in;
   logic [7:0]             row_ff, row_in;
   logic [8:0]             row_next9, adv9, tab9, cols9;
   logic                   check;
   rsp_type                res;

   rsp_type                q_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   res_full, exec, do_pop;

   assign cols9 = {1'b0, cfg.text_columns};
   assign adv9  = {1'b0, col_ff} + 9'd1;
   assign tab9  = ({1'b0, col_ff} + 9'(TAB_STOP)) & ~9'(TAB_STOP - 1);

   always_comb begin
      col_in    = col_ff;
      row_next9 = {1'b0, row_ff};
      check     = 1'b0;
      res       = '0;
      case (cmd_head.op)
         OP_SET: begin
            col_in    = cmd_head.col;
            row_next9 = {1'b0, cmd_head.row};
         end
         OP_CLEAR: begin
            res.clear_request = cmd_head.clear_flag;
            col_in            = '0;
            row_next9         = '0;
         end
         OP_NEWLINE: begin
            col_in    = '0;
            row_next9 = {1'b0, row_ff} + 9'd1;
            check     = 1'b1;
         end
         OP_RETURN: begin
            col_in = '0;
         end
         OP_BACKSPACE: begin
            if (col_ff != 8'd0) begin
               col_in         = col_ff - 8'd1;
               res.draw_valid = 1'b1;
               res.glyph_code = CHAR_SPACE;
               res.glyph_col  = col_ff - 8'd1;
               res.glyph_row  = row_ff;
            end
         end
         OP_TAB: begin
            check = 1'b1;
            if (tab9 >= cols9) begin
               col_in    = '0;
               row_next9 = {1'b0, row_ff} + 9'd1;
            end else begin
               col_in = tab9[7:0];
            end
         end
         OP_GLYPH: begin
            res.draw_valid = 1'b1;
            res.glyph_code = cmd_head.code;
            res.glyph_col  = col_ff;
            res.glyph_row  = row_ff;
            check          = 1'b1;
            if (adv9 >= cols9) begin
               col_in    = '0;
               row_next9 = {1'b0, row_ff} + 9'd1;
            end else begin
               col_in = adv9[7:0];
            end
         end
         default: begin
            col_in = col_ff;
         end
      endcase
      // row check; a zero row count clamps to 255
      if (check && row_next9 >= {1'b0, cfg.text_rows}) begin
         res.scroll_request = 1'b1;
         row_in             = cfg.text_rows - 8'd1;
      end else begin
         row_in = row_next9[7:0];
      end
      res.cursor_col = col_in;
      res.cursor_row = row_in;
   end

   // result queue
   assign res_full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign rsp_empty = (count_ff == '0);
   assign exec      = ~cmd_empty & ~res_full;
   assign cmd_pop   = exec;
   assign do_pop    = rsp_pop & ~rsp_empty;
   assign rsp_data  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (exec) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (exec && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !exec) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         if (exec) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         q_ff[wr_ptr_ff] <= res;
      end
   end

endmodule
`default_nettype wire

### rtl/core/utf8_text_console_cursor_engine_unit.sv
// Top level of the UTF-8 text console cursor engine.
//
// Usage:
//   Input beats arrive on req_push/req_full with req_data (func, data_byte,
//   new_col, new_row). A beat is taken on a clock edge with req_push high
//   and req_full low. Every beat gives exactly one result beat, in order.
//   Results wait on rsp_data while rsp_empty is low and leave on an edge
//   with rsp_pop high. Registers (text_columns, text_rows, console_enable)
//   go through csr_wr_en/csr_index/csr_wdata; the user must write them
//   only while idle, since the block itself does not enforce it.
//
// Timing:
//   Each beat's command enters the command queue on the edge taking the
//   beat; the back end writes its result into the result queue when that
//   has room. One beat per cycle is sustained while results are popped, as
//   the cursor update is combinational. With two-beat queues, a stalled
//   consumer fills the result queue, then the command, then raises req_full.
//
// Reset (synchronous, active high) empties both queues, homes the cursor,
// drops any partial UTF-8 sequence and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module utf8_text_console_cursor_engine_unit
   import ucce_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  req_type                req_data,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output rsp_type                rsp_data,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata
);

   cfg_type cfg_ff;
   logic    cmd_push, cmd_full, cmd_empty, cmd_pop;
   cmd_type cmd_data, cmd_head;

   // register file; writes to unused indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.text_columns   <= RESET_TEXT_COLUMNS;
         cfg_ff.text_rows      <= RESET_TEXT_ROWS;
         cfg_ff.console_enable <= RESET_CONSOLE_ENABLE;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TEXT_COLUMNS:   cfg_ff.text_columns   <= csr_wdata;
            CSR_TEXT_ROWS:      cfg_ff.text_rows      <= csr_wdata;
            CSR_CONSOLE_ENABLE: cfg_ff.console_enable <= csr_wdata[0];
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   // decode and classify
   ucce_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .cmd_push (cmd_push),
      .cmd_data (cmd_data),
      .cmd_full (cmd_full)
   );

   ucce_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .empty     (cmd_empty),
      .head      (cmd_head)
   );

   // cursor update and result queue
   ucce_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_empty (cmd_empty),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

### rtl/core/ucce_checker.sv
// Port-level checker for the cursor engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_text_console_cursor_engine_unit_macros.svh"
module ucce_checker
   import ucce_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_full,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_data
);

   `UCCE_ASSERT_RESET(a_reset_idle, clock, reset |=> rsp_empty && !req_full, "queues not empty after reset")

   `UCCE_ASSERT_ALWAYS(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data), "stalled result beat changed")

   `UCCE_ASSERT_ALWAYS(a_no_draw_zero, clock, reset, !rsp_empty && !rsp_data.draw_valid |-> rsp_data.glyph_code == 8'd0 && rsp_data.glyph_col == 8'd0 && rsp_data.glyph_row == 8'd0, "glyph fields set without draw")

   `UCCE_ASSERT_ALWAYS(a_clear_home, clock, reset, !rsp_empty && rsp_data.clear_request |-> rsp_data.cursor_col == 8'd0 && rsp_data.cursor_row == 8'd0 && !rsp_data.draw_valid && !rsp_data.scroll_request, "clear beat not homed")

endmodule

bind utf8_text_console_cursor_engine_unit ucce_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);
`default_nettype wire
